// ----- rtl/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// shared types and constants for the star-only wildcard matcher
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int PATTERN_MAX_DEF     = 63;
    localparam int WORD_LENGTH_MAX_DEF = 255;
    localparam int CHAR_W              = 8;
    localparam int WORD_LEN_W          = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'd42;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_CHAR   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [CHAR_W-1:0] ch;
    } in_word_t;

    typedef struct packed {
        logic                  matched;
        logic [WORD_LEN_W-1:0] word_length;
        logic                  pattern_overflow;
    } out_word_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic              restart;
        logic              step;
        logic [CHAR_W-1:0] ch;
    } cell_ctl_t;

    // what a cell reports back for the closure network and its neighbor
    typedef struct packed {
        logic raw;
        logic prop;
        logic adv;
    } cell_stat_t;

endpackage

// ----- rtl/wsm_cell.sv -----
// ----------------------------------------------------------------------------
// wsm_cell
// one pattern position: stored char and the raw active bit of the position
// ----------------------------------------------------------------------------
module wsm_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wsm_pkg::cell_ctl_t              ctl,
    input  logic                            wr_en,
    input  logic                            pos_valid,
    input  logic                            closed,
    input  logic                            adv_in,
    output wsm_pkg::cell_stat_t             stat
);

    logic [wsm_pkg::CHAR_W-1:0] char_reg;
    logic                       raw_reg;
    logic                       raw_next;
    logic                       is_star;
    logic                       keep;

    assign is_star = (char_reg == wsm_pkg::STAR_CHAR);
    // star stays put on any char, literal moves to the next position on a hit
    assign keep    = pos_valid & closed & is_star;

    assign stat.raw  = raw_reg;
    assign stat.prop = pos_valid & is_star;
    assign stat.adv  = pos_valid & closed & ~is_star & (char_reg == ctl.ch);

    always_comb begin
        raw_next = raw_reg;
        if (ctl.restart) begin
            raw_next = IS_FIRST;
        end else if (ctl.step) begin
            raw_next = keep | adv_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg <= IS_FIRST;
        end else begin
            raw_reg <= raw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            char_reg <= ctl.ch;
        end
    end

endmodule

// ----- rtl/wsm_closure.sv -----
// ----------------------------------------------------------------------------
// wsm_closure
// star closure of the raw active set as a parallel prefix network
// ----------------------------------------------------------------------------
module wsm_closure #(
    parameter int N = 64
) (
    input  logic [N-1:0] gen_in,
    input  logic [N-2:0] prop_in,
    output logic [N-1:0] closed
);

    localparam int LEVELS = $clog2(N);

    always_comb begin
        logic [N-1:0] g_cur;
        logic [N-1:0] p_cur;
        logic [N-1:0] g_prev;
        logic [N-1:0] p_prev;
        int           d;
        g_cur = gen_in;
        // span of position j starts as the pattern char just below it
        p_cur = {prop_in, 1'b0};
        for (int k = 0; k < LEVELS; k++) begin
            d      = 1 << k;
            g_prev = g_cur;
            p_prev = p_cur;
            for (int j = 0; j < N; j++) begin
                if (j >= d) begin
                    g_cur[j] = g_prev[j] | (p_prev[j] & g_prev[j-d]);
                    p_cur[j] = p_prev[j] & p_prev[j-d];
                end else begin
                    p_cur[j] = 1'b0;
                end
            end
        end
        closed = g_cur;
    end

endmodule

// ----- rtl/wildcard_star_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_star_matcher
// streamed star-only glob matcher over a stored pattern
// ----------------------------------------------------------------------------
// Input words are accepted back to back: clear, pattern append, word char and
// end of word alike, and a result is ready in the output register in the
// cycle after its end-of-word word is taken. Only an end-of-word word
// waits, and only while the previous result is still held by m_ready low;
// all other words keep flowing. The pattern lives in a row of PATTERN_MAX
// cells, each with its char and the raw active bit of its position; the
// cycle path is the star closure (a prefix network of log2(PATTERN_MAX+1)
// levels) followed by one byte compare in each cell. The active set is kept
// before closure, so a clear or an append only resets it to position zero.
// ----------------------------------------------------------------------------
module wildcard_star_matcher #(
    parameter int PATTERN_MAX     = wsm_pkg::PATTERN_MAX_DEF,
    parameter int WORD_LENGTH_MAX = wsm_pkg::WORD_LENGTH_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wsm_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wsm_pkg::out_word_t m_data
);

    localparam int NPOS  = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(NPOS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
    localparam logic [wsm_pkg::WORD_LEN_W-1:0] WC_MAX =
        wsm_pkg::WORD_LEN_W'(WORD_LENGTH_MAX);
    localparam logic [wsm_pkg::WORD_LEN_W-1:0] WC_ONE =
        wsm_pkg::WORD_LEN_W'(1);

    // handshake
    logic s_fire;
    logic is_clear, is_append, is_char, is_end;

    // pattern and word state
    logic [LEN_W-1:0]               len_reg, len_next;
    logic                           ovf_reg, ovf_next;
    logic [wsm_pkg::WORD_LEN_W-1:0] wc_reg, wc_next;
    logic                           raw_end_reg, raw_end_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    wsm_pkg::out_word_t m_data_reg;

    // cell row
    wsm_pkg::cell_ctl_t             ctl;
    wsm_pkg::cell_stat_t            stat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]         pos_valid;
    logic [PATTERN_MAX-1:0]         prop_vec;
    logic [NPOS-1:0]                raw_vec;
    logic [NPOS-1:0]                closed_vec;
    logic [NPOS-1:0]                pos_mask;

    // end of word only waits for a free output register
    assign s_ready = ~m_valid_reg | m_ready | (s_data.action != wsm_pkg::ACT_END);
    assign s_fire  = s_valid & s_ready;

    assign is_clear  = s_fire & (s_data.action == wsm_pkg::ACT_CLEAR);
    assign is_append = s_fire & (s_data.action == wsm_pkg::ACT_APPEND);
    assign is_char   = s_fire & (s_data.action == wsm_pkg::ACT_CHAR);
    assign is_end    = s_fire & (s_data.action == wsm_pkg::ACT_END);

    // any pattern change or finished word starts the next word fresh
    assign ctl.restart = is_clear | is_append | is_end;
    assign ctl.step    = is_char;
    assign ctl.ch      = s_data.ch;

    // positions in use and the valid-position mask for checking
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos_valid[i] = (LEN_W'(i) < len_reg);
        end
        for (int j = 0; j < NPOS; j++) begin
            pos_mask[j] = (LEN_W'(j) <= len_reg);
        end
    end

    // row of cells, each handing its advance bit to the right neighbor
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        logic adv_in;
        if (i == 0) begin : g_first
            assign adv_in = 1'b0;
        end else begin : g_rest
            assign adv_in = stat[i-1].adv;
        end

        wsm_cell #(
            .IS_FIRST (i == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .wr_en     (is_append & (len_reg == LEN_W'(i))),
            .pos_valid (pos_valid[i]),
            .closed    (closed_vec[i]),
            .adv_in    (adv_in),
            .stat      (stat[i])
        );

        assign raw_vec[i]  = stat[i].raw;
        assign prop_vec[i] = stat[i].prop;
    end

    // final position exists past the last cell
    assign raw_vec[PATTERN_MAX] = raw_end_reg;

    wsm_closure #(
        .N (NPOS)
    ) u_closure (
        .gen_in  (raw_vec),
        .prop_in (prop_vec),
        .closed  (closed_vec)
    );

    always_comb begin
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        wc_next      = wc_reg;
        raw_end_next = raw_end_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        if (is_clear) begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        if (is_append) begin
            if (len_reg < LEN_MAX) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (ctl.restart) begin
            wc_next      = '0;
            raw_end_next = 1'b0;
        end else if (is_char) begin
            raw_end_next = stat[PATTERN_MAX-1].adv;
            if (wc_reg < WC_MAX) begin
                wc_next = wc_reg + WC_ONE;
            end
        end
        if (is_end) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            wc_reg      <= '0;
            raw_end_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            wc_reg      <= wc_next;
            raw_end_reg <= raw_end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (is_end) begin
            m_data_reg.matched          <= closed_vec[len_reg];
            m_data_reg.word_length      <= wc_reg;
            m_data_reg.pattern_overflow <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // no active position ever lies beyond the pattern end
    a_raw_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (raw_vec & ~pos_mask) == '0)
        else $error("active position beyond pattern length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("pattern length out of range");

    a_wc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wc_reg <= WC_MAX)
        else $error("word count past saturation");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        is_end |=> m_valid_reg && (m_data_reg.word_length == $past(wc_reg)))
        else $error("end of word gave no result");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        is_clear |=> (len_reg == '0) && !ovf_reg && (raw_vec == NPOS'(1)))
        else $error("clear did not reset pattern state");

endmodule
